@@ sv/sots_pkg.sv @@
package sots_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int MAG_W = 33;

  typedef struct packed {
    logic        is_query;
    logic [5:0]  entry_index;
    logic [15:0] entry_soc;
    logic [15:0] entry_ocv;
    logic [15:0] measured_ocv;
    logic [15:0] prev_soc;
    logic [1:0]  charge_direction;
  } item_t;

  function automatic logic [15:0] dist16(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // charging wants cand >= prev, discharging wants cand <= prev
  function automatic logic dir_ok(input logic [15:0] c, input logic [15:0] p,
                                  input logic [1:0] dir);
    logic r;
    if (dir[1]) r = (c >= p);
    else if (dir[0]) r = (c <= p);
    else r = 1'b1;
    return r;
  endfunction

  function automatic logic [15:0] clamp_soc(input logic signed [17:0] x,
                                            input logic [15:0] lo, input logic [15:0] hi);
    logic [15:0] r;
    if (x < $signed({2'b00, lo})) r = lo;
    else if (x > $signed({2'b00, hi})) r = hi;
    else r = x[15:0];
    return r;
  endfunction

endpackage

@@ sv/sots_front.sv @@
module sots_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  sots_pkg::item_t in_item,
  output logic            q_valid,
  output sots_pkg::item_t q_item,
  input  logic            q_pop
);

  sots_pkg::item_t fifo_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;
  logic            push;
  logic            pop;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= in_item;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ sv/sots_engine.sv @@
module sots_engine #(
  parameter int TABLE_DEPTH = sots_pkg::TABLE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [6:0]      cfg_data,
  input  logic            q_valid,
  input  sots_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [15:0]     out_soc_estimate,
  output logic            out_interval_found,
  output logic            out_table_too_short
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int MW = sots_pkg::MAG_W;
  localparam int CW = $clog2(MW + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_LO    = 12'b000000000010,
    S_HI    = 12'b000000000100,
    S_ROW   = 12'b000000001000,
    S_CHK   = 12'b000000010000,
    S_DVI   = 12'b000000100000,
    S_DIV   = 12'b000001000000,
    S_CAND  = 12'b000010000000,
    S_SCORE = 12'b000100000000,
    S_NEXT  = 12'b001000000000,
    S_FIN   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] soc_mem [TABLE_DEPTH];
  logic [15:0] ocv_mem [TABLE_DEPTH];
  logic [15:0] rd_soc_r, rd_ocv_r;
  logic [AW-1:0] rd_addr;

  logic [6:0]    ent_r;
  logic [NW-1:0] n_sat;
  logic [AW-1:0] last_r;
  logic [AW-1:0] i_r;

  logic [15:0] meas_r, prev_r, lo_r, hi_r;
  logic [1:0]  dir_r;
  logic [15:0] a_soc_r, a_ocv_r, b_soc_r, b_ocv_r;
  logic [15:0] vmin_r, smin_r, vmax_r, smax_r;
  logic [15:0] cand_r;
  logic        found_r;
  logic [16:0] best_sc_r;
  logic [15:0] best_r;

  logic signed [33:0] prod_r;
  logic [15:0]        den_r;
  logic               neg_r;
  logic [16:0]        rem_r;
  logic [MW-1:0]      quo_r;
  logic [CW-1:0]      cnt_r;

  logic [15:0] res_soc_r;
  logic        res_found_r, res_short_r;
  logic        out_valid_r;
  logic [15:0] out_soc_r;
  logic        out_found_r, out_short_r;

  logic        hit;
  logic        flat;
  logic [15:0] vl, vh;
  logic [15:0] fa, fb, fc, fo;
  logic signed [16:0] dv, ds, dd;
  logic signed [33:0] prod;
  logic [16:0] dtry;
  logic [15:0] qmag;
  logic signed [17:0] qs;
  logic [16:0] sc;
  logic        near_min;
  logic [15:0] c1, c2, fbest;
  logic [15:0] prev_cl;
  logic        out_free;

  assign n_sat  = ({25'd0, ent_r} > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(ent_r);
  assign q_pop  = (state_r == S_IDLE) && q_valid;
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid           = out_valid_r;
  assign out_soc_estimate    = out_soc_r;
  assign out_interval_found  = out_found_r;
  assign out_table_too_short = out_short_r;

  always_comb begin
    case (state_r)
      S_LO:    rd_addr = last_r;
      S_HI:    rd_addr = AW'(1);
      S_NEXT:  rd_addr = i_r + 1'b1;
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    vl   = (a_ocv_r < b_ocv_r) ? a_ocv_r : b_ocv_r;
    vh   = (a_ocv_r < b_ocv_r) ? b_ocv_r : a_ocv_r;
    hit  = (meas_r >= vl) && (meas_r <= vh);
    flat = (a_ocv_r == b_ocv_r);
    fa   = (a_soc_r <= b_soc_r) ? a_soc_r : b_soc_r;
    fb   = (a_soc_r <= b_soc_r) ? b_soc_r : a_soc_r;
    if (dir_r[1]) fc = fb;
    else if (dir_r[0]) fc = fa;
    else fc = (sots_pkg::dist16(fa, prev_r) <= sots_pkg::dist16(fb, prev_r)) ? fa : fb;
    fo = (fc == fa) ? fb : fa;
    if (dir_r != 2'b00 && !sots_pkg::dir_ok(fc, prev_r, dir_r) &&
        sots_pkg::dir_ok(fo, prev_r, dir_r)) begin
      fc = fo;
    end
    dv   = $signed({1'b0, meas_r}) - $signed({1'b0, a_ocv_r});
    ds   = $signed({1'b0, b_soc_r}) - $signed({1'b0, a_soc_r});
    dd   = $signed({1'b0, b_ocv_r}) - $signed({1'b0, a_ocv_r});
    prod = dv * ds;
    dtry = {rem_r[15:0], quo_r[MW-1]};
    qmag = quo_r[15:0];
    qs   = neg_r ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
    sc   = {(dir_r != 2'b00) && !sots_pkg::dir_ok(cand_r, prev_r, dir_r),
            sots_pkg::dist16(cand_r, prev_r)};
    near_min = sots_pkg::dist16(meas_r, vmin_r) <= sots_pkg::dist16(meas_r, vmax_r);
    c1 = near_min ? smin_r : smax_r;
    c2 = near_min ? smax_r : smin_r;
    if (dir_r != 2'b00 && sots_pkg::dir_ok(c1, prev_r, dir_r)) fbest = c1;
    else if (dir_r != 2'b00 && sots_pkg::dir_ok(c2, prev_r, dir_r)) fbest = c2;
    else fbest = (sots_pkg::dist16(c1, prev_r) <= sots_pkg::dist16(c2, prev_r)) ? c1 : c2;
    prev_cl = sots_pkg::clamp_soc($signed({2'b00, prev_r}), lo_r, rd_soc_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid && q_item.is_query) state_nxt = (n_sat < NW'(2)) ? S_OUT : S_LO;
      end
      S_LO:    state_nxt = S_HI;
      S_HI:    state_nxt = S_ROW;
      S_ROW:   state_nxt = S_CHK;
      S_CHK:   state_nxt = !hit ? S_NEXT : (flat ? S_SCORE : S_DVI);
      S_DVI:   state_nxt = S_DIV;
      S_DIV:   state_nxt = (cnt_r == CW'(MW - 1)) ? S_CAND : S_DIV;
      S_CAND:  state_nxt = S_SCORE;
      S_SCORE: state_nxt = S_NEXT;
      S_NEXT:  state_nxt = (i_r == last_r) ? S_FIN : S_ROW;
      S_FIN:   state_nxt = S_OUT;
      S_OUT:   state_nxt = out_free ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_soc_r <= soc_mem[rd_addr];
    rd_ocv_r <= ocv_mem[rd_addr];
    if (state_r == S_IDLE && q_valid && !q_item.is_query &&
        32'(q_item.entry_index) < TABLE_DEPTH) begin
      soc_mem[AW'(q_item.entry_index)] <= q_item.entry_soc;
      ocv_mem[AW'(q_item.entry_index)] <= q_item.entry_ocv;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        meas_r  <= q_item.measured_ocv;
        prev_r  <= q_item.prev_soc;
        dir_r   <= q_item.charge_direction;
        last_r  <= AW'(n_sat - 1'b1);
        found_r <= 1'b0;
        res_soc_r   <= q_item.prev_soc;
        res_found_r <= 1'b0;
        res_short_r <= 1'b1;
      end
      S_LO: begin
        lo_r    <= rd_soc_r;
        a_soc_r <= rd_soc_r;
        a_ocv_r <= rd_ocv_r;
        vmin_r  <= rd_ocv_r;
        vmax_r  <= rd_ocv_r;
        smin_r  <= rd_soc_r;
        smax_r  <= rd_soc_r;
      end
      S_HI: begin
        hi_r   <= rd_soc_r;
        prev_r <= prev_cl;
        i_r    <= AW'(1);
      end
      S_ROW: begin
        b_soc_r <= rd_soc_r;
        b_ocv_r <= rd_ocv_r;
        if (rd_ocv_r < vmin_r) begin
          vmin_r <= rd_ocv_r;
          smin_r <= rd_soc_r;
        end
        if (rd_ocv_r > vmax_r) begin
          vmax_r <= rd_ocv_r;
          smax_r <= rd_soc_r;
        end
      end
      S_CHK: begin
        cand_r <= sots_pkg::clamp_soc($signed({2'b00, fc}), lo_r, hi_r);
        prod_r <= prod;
        den_r  <= dd[16] ? 16'(-dd) : dd[15:0];
        neg_r  <= dd[16];
      end
      S_DVI: begin
        neg_r <= neg_r ^ prod_r[33];
        quo_r <= prod_r[33] ? MW'(-prod_r) : prod_r[MW-1:0];
        rem_r <= '0;
        cnt_r <= '0;
      end
      S_DIV: begin
        if (dtry >= {1'b0, den_r}) begin
          rem_r <= dtry - {1'b0, den_r};
          quo_r <= {quo_r[MW-2:0], 1'b1};
        end else begin
          rem_r <= dtry;
          quo_r <= {quo_r[MW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
      end
      S_CAND: begin
        cand_r <= sots_pkg::clamp_soc($signed({2'b00, a_soc_r}) + qs, lo_r, hi_r);
      end
      S_SCORE: begin
        if (!found_r || sc < best_sc_r) begin
          found_r   <= 1'b1;
          best_sc_r <= sc;
          best_r    <= cand_r;
        end
      end
      S_NEXT: begin
        a_soc_r <= b_soc_r;
        a_ocv_r <= b_ocv_r;
        i_r     <= i_r + 1'b1;
      end
      S_FIN: begin
        res_short_r <= 1'b0;
        res_found_r <= found_r;
        res_soc_r   <= found_r ? best_r
                               : sots_pkg::clamp_soc($signed({2'b00, fbest}), lo_r, hi_r);
      end
      default: begin
      end
    endcase
    if (state_r == S_OUT && out_free) begin
      out_soc_r   <= res_soc_r;
      out_found_r <= res_found_r;
      out_short_r <= res_short_r;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ent_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) ent_r <= cfg_data;
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

endmodule

@@ sv/soc_from_ocv_table_search.sv @@
// SOC lookup from an (SOC, OCV) table. A load item (command 0) writes one row;
// a query (command 1) returns one result. A query runs on a single sequencer
// that reads the table memory one row per step: setup reads the first and
// last rows, then each interval scanned takes a row read, a check and a step
// to the next row; a sloped interval that holds the voltage adds an
// interpolation through a 33-step shift-subtract divider and a scoring step,
// a flat one adds only the scoring step; a finish step then picks the result,
// which may wait on out_stall. A table shorter than two rows skips the scan
// and answers with out_table_too_short set. A two-entry queue in front takes
// items while a query runs, and an output register holds the last result.
// entries_in_use is written on the cfg port, which is always ready.
module soc_from_ocv_table_search #(
  parameter int TABLE_DEPTH = sots_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_entries_in_use,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [5:0]  in_entry_index,
  input  logic [15:0] in_entry_soc,
  input  logic [15:0] in_entry_ocv,
  input  logic [15:0] in_measured_ocv,
  input  logic [15:0] in_prev_soc,
  input  logic signed [1:0] in_charge_direction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_soc_estimate,
  output logic        out_interval_found,
  output logic        out_table_too_short
);

  sots_pkg::item_t in_item;
  sots_pkg::item_t q_item;
  logic            q_valid;
  logic            q_pop;

  assign cfg_ready = 1'b1;

  assign in_item.is_query         = in_command;
  assign in_item.entry_index      = in_entry_index;
  assign in_item.entry_soc        = in_entry_soc;
  assign in_item.entry_ocv        = in_entry_ocv;
  assign in_item.measured_ocv     = in_measured_ocv;
  assign in_item.prev_soc         = in_prev_soc;
  assign in_item.charge_direction = in_charge_direction;

  sots_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  sots_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_data            (cfg_entries_in_use),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_soc_estimate    (out_soc_estimate),
    .out_interval_found  (out_interval_found),
    .out_table_too_short (out_table_too_short)
  );

endmodule
